// ----- hw/rtl/chc_pkg.sv -----
// Shared types and constants for the Chaocipher encipherer.
// Depends on nothing; imported by chc_ring and chaocipher_encipher.
`default_nettype none

package chc_pkg;

    localparam int unsigned MIN_WHEEL = 4;
    localparam int unsigned SYM_W     = 8;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned LEN_W     = 8;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_ENCIPHER = 1'b1;

    // Positions of the slots that are taken out by the nadir move.
    localparam int unsigned CIPHER_PICK = 1;
    localparam int unsigned PLAIN_PICK  = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEARCH,
        ST_RESULT,
        ST_COPY
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/chc_ring.sv -----
// One wheel store: a simple dual-port memory with one write port and a
// registered read port. Depends on chc_pkg for the byte width.
`default_nettype none

module chc_ring
    import chc_pkg::*;
#(
    parameter int unsigned ADDR_W = 8
)
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire logic [SYM_W-1:0]    wdata,
    input  wire logic [ADDR_W-1:0]   raddr,
    output logic      [SYM_W-1:0]    rdata
);

    logic [SYM_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/chaocipher_encipher.sv -----
// Top level of the Chaocipher encipherer: control sequencer and the two wheels.
// Depends on chc_pkg and chc_ring.
`default_nettype none

// Each wheel is held in two banks of one memory. An encipher transfer scans the
// current bank from slot 0 for the symbol (one slot per cycle), hands the
// result to the output register, and then, if the symbol was found, copies the
// wheel into the other bank with the rotation and nadir move folded into the
// read address, after which the banks swap. When the previous copy pass ran
// with a longer wheel, the pass also copies the slots up to that older length
// unchanged, so that both banks agree on every slot at L and above, with L the
// clamped wheel length. A load writes both banks. A new transfer is accepted
// only in idle, after the copy pass through the memory read port is done.
// wheel_length is clamped to 4..MAX_WHEEL and must be written idle.

module chaocipher_encipher
    import chc_pkg::*;
#(
    parameter int unsigned MAX_WHEEL = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [6:0] position, [14:7] plain_entry, [22:15] cipher_entry, [30:23] symbol
    input  wire logic [31:0] s_tdata,
    // [0] command
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] code
    output logic [7:0]       m_tdata,
    // [0] found
    output logic [0:0]       m_tuser
);

    localparam int unsigned AW = $clog2(MAX_WHEEL);
    localparam int unsigned LW = AW + 1;

    state_t state_reg, state_next;

    logic [LEN_W-1:0] wlen_reg;
    logic             bank_reg, bank_next;
    logic [LW-1:0]    k_reg, k_next;
    logic [LW-1:0]    dirty_reg, dirty_next;
    logic             rd_valid_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic [POS_W-1:0] pos_reg;
    logic [SYM_W-1:0] pe_reg, ce_reg, sym_reg;
    logic             hit_reg, hit_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [SYM_W-1:0] code_reg, code_next;
    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_code_reg;
    logic             out_found_reg;

    logic             accept;
    logic             issue;
    logic             load_out;
    logic [LW-1:0]    len;
    logic [LW-1:0]    half;
    logic [LW-1:0]    copy_len;
    logic             pos_ok;
    logic [AW-1:0]    pos_in_idx, pos_reg_idx;

    logic [SYM_W-1:0] p_q, c_q;
    logic             p_we, c_we;
    logic [AW:0]      p_waddr, c_waddr, p_raddr, c_raddr;
    logic [SYM_W-1:0] p_wdata, c_wdata;

    logic [LW-1:0]    rot_c, rot_p, j_ext, j_inc;
    logic [LW-1:0]    g_c, g_p;
    logic [LW:0]      sum_c, sum_p;
    logic [LW-1:0]    src_c, src_p;
    logic             match, last;

    // Effective wheel length.
    always_comb
    begin
        if (wlen_reg < LEN_W'(MIN_WHEEL))
            len = LW'(MIN_WHEEL);
        else if (int'(wlen_reg) > int'(MAX_WHEEL))
            len = LW'(MAX_WHEEL);
        else
            len = LW'(wlen_reg);
    end

    // The copy pass covers the slots where the two banks may differ.
    assign copy_len    = (dirty_reg > len) ? dirty_reg : len;
    assign half        = len >> 1;
    assign accept      = s_tvalid && s_tready;
    assign pos_ok      = int'(s_tdata[6:0]) < int'(MAX_WHEEL);
    assign pos_in_idx  = AW'(s_tdata[6:0]);
    assign pos_reg_idx = AW'(pos_reg);
    assign issue       = ((state_reg == ST_SEARCH) && (k_reg < len)) ||
                         ((state_reg == ST_COPY) && (k_reg < copy_len));
    assign match       = rd_valid_reg && (p_q == sym_reg);
    assign last        = rd_valid_reg && ({1'b0, rd_idx_reg} == len - LW'(1));
    assign load_out    = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);

    // Source slot for the copy pass: rotate by rot, then the slot at pick moves
    // to the nadir (half the length) while those between shift one place towards slot 0.
    assign j_ext = {1'b0, j_reg};
    assign j_inc = (j_ext + LW'(1) == len) ? '0 : j_ext + LW'(1);
    assign rot_c = j_ext;
    assign rot_p = j_inc;

    always_comb
    begin
        if (k_reg == half)
            g_c = LW'(CIPHER_PICK);
        else if (k_reg >= LW'(CIPHER_PICK) && k_reg < half)
            g_c = k_reg + LW'(1);
        else
            g_c = k_reg;

        if (k_reg == half)
            g_p = LW'(PLAIN_PICK);
        else if (k_reg >= LW'(PLAIN_PICK) && k_reg < half)
            g_p = k_reg + LW'(1);
        else
            g_p = k_reg;
    end

    // Slots beyond the wheel length are copied in place.
    assign sum_c = {1'b0, rot_c} + {1'b0, g_c};
    assign sum_p = {1'b0, rot_p} + {1'b0, g_p};
    assign src_c = (k_reg >= len) ? k_reg :
                   (sum_c >= {1'b0, len}) ? LW'(sum_c - {1'b0, len}) : LW'(sum_c);
    assign src_p = (k_reg >= len) ? k_reg :
                   (sum_p >= {1'b0, len}) ? LW'(sum_p - {1'b0, len}) : LW'(sum_p);

    // Memory port control.
    always_comb
    begin
        p_we    = 1'b0;
        c_we    = 1'b0;
        p_waddr = {bank_reg, pos_in_idx};
        c_waddr = {bank_reg, pos_in_idx};
        p_wdata = s_tdata[14:7];
        c_wdata = s_tdata[22:15];
        p_raddr = {bank_reg, k_reg[AW-1:0]};
        c_raddr = {bank_reg, k_reg[AW-1:0]};
        case (state_reg)
            ST_IDLE:
            begin
                p_we = accept && (s_tuser[0] == CMD_LOAD) && pos_ok;
                c_we = p_we;
            end
            ST_LOAD:
            begin
                p_we    = 1'b1;
                c_we    = 1'b1;
                p_waddr = {~bank_reg, pos_reg_idx};
                c_waddr = {~bank_reg, pos_reg_idx};
                p_wdata = pe_reg;
                c_wdata = ce_reg;
            end
            ST_COPY:
            begin
                p_we    = rd_valid_reg;
                c_we    = rd_valid_reg;
                p_waddr = {~bank_reg, rd_idx_reg};
                c_waddr = {~bank_reg, rd_idx_reg};
                p_wdata = p_q;
                c_wdata = c_q;
                p_raddr = {bank_reg, src_p[AW-1:0]};
                c_raddr = {bank_reg, src_c[AW-1:0]};
            end
            default:
            begin
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == CMD_ENCIPHER)
                        state_next = ST_SEARCH;
                    else if (pos_ok)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_IDLE;
            ST_SEARCH:
            begin
                if (match || last)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (load_out)
                    state_next = hit_reg ? ST_COPY : ST_IDLE;
            end
            ST_COPY:
            begin
                if (!issue)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        bank_next      = bank_reg;
        dirty_next     = dirty_reg;
        k_next         = issue ? k_reg + LW'(1) : '0;
        hit_next       = hit_reg;
        j_next         = j_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_SEARCH:
            begin
                if (match)
                begin
                    hit_next  = 1'b1;
                    j_next    = rd_idx_reg;
                    code_next = c_q;
                end
                else if (last)
                begin
                    hit_next  = 1'b0;
                    code_next = sym_reg;
                end
            end
            ST_RESULT:
            begin
                if (load_out)
                    out_valid_next = 1'b1;
            end
            ST_COPY:
            begin
                if (!issue)
                begin
                    bank_next  = ~bank_reg;
                    dirty_next = len;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= 8'd26;
            bank_reg      <= 1'b0;
            dirty_reg     <= '0;
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                wlen_reg  <= cfg_wdata;
            bank_reg      <= bank_next;
            dirty_reg     <= dirty_next;
            k_reg         <= k_next;
            rd_valid_reg  <= issue;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= k_reg[AW-1:0];
        j_reg      <= j_next;
        code_reg   <= code_next;
        if (accept)
        begin
            pos_reg <= s_tdata[6:0];
            pe_reg  <= s_tdata[14:7];
            ce_reg  <= s_tdata[22:15];
            sym_reg <= s_tdata[30:23];
        end
        if (load_out)
        begin
            out_code_reg  <= code_reg;
            out_found_reg <= hit_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tuser  = out_found_reg;

    chc_ring #(.ADDR_W(AW + 1)) u_plain_ring
    (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_q)
    );

    chc_ring #(.ADDR_W(AW + 1)) u_cipher_ring
    (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_q)
    );

`ifndef SYNTHESIS
    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> ($past(state_reg) == ST_COPY))
        else $error("wheel banks swapped outside the copy pass");

    a_copy_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && $past(state_reg) == ST_RESULT) |-> hit_reg)
        else $error("copy pass started for a symbol not on the wheel");

    a_result_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_valid_reg && !m_tready) |=> (state_reg == ST_RESULT))
        else $error("result left while the output register was still full");
`endif

endmodule

`default_nettype wire
